/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Both take a label, the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an expression on every clock edge outside reset.
`define RTPN_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("rtpn assertion failed");
// Check that an antecedent implies a consequent on the next edge.
`define RTPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtpn assertion failed");
`else
`define RTPN_ASSERT(lbl, clk, rst_n, expr)
`define RTPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/rtpn_pkg.sv */
package rtpn_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;

	localparam logic [15:0] HALF_SPACE = 16'h8000;

	// Register reset values
	localparam logic [15:0] INIT_DELAY_RST = 16'd0;
	localparam logic [15:0] RETRY_RST      = 16'd20;
	localparam logic [7:0]  MAX_ATT_RST    = 8'd3;
	localparam logic [6:0]  MAX_PEND_RST   = 7'd64;

	typedef enum logic [1:0] {
		REG_INIT_DELAY = 2'd0,
		REG_RETRY      = 2'd1,
		REG_MAX_ATT    = 2'd2,
		REG_MAX_PEND   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_ABANDON = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_BEFORE = 2'd1,
		KIND_AFTER  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OBS_SCAN,
		S_OBS_INS,
		S_TICK_SCAN,
		S_TICK_SEL,
		S_TICK_EMIT,
		S_ABN_SCAN,
		S_OUT
	} state_t;

	// One table entry
	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] due;
		logic [7:0]  attempts;
		logic [63:0] order;
	} entry_t;

	// Per-entry compare results
	typedef struct packed {
		logic        seq_eq;
		logic [15:0] diff;
		logic        due_ok;
		logic        att_ok;
		logic        order_lt;
		logic        never_sent;
	} eval_t;

	// One result word
	typedef struct packed {
		logic        nack_valid;
		logic [15:0] nack_seq;
		logic        last_result;
		logic [1:0]  recovered_kind;
		logic        new_source;
		logic [6:0]  gap_recorded;
		logic [14:0] gap_ignored;
		logic        exhausted_now;
		logic [6:0]  pending_count;
	} result_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic result_t make_result(
		input logic nv, input logic [15:0] ns, input logic last, input logic [1:0] kind,
		input logic nsrc, input logic [6:0] rec, input logic [14:0] ign, input logic ex,
		input logic [6:0] pc);
		result_t r;
		r.nack_valid     = nv;
		r.nack_seq       = ns;
		r.last_result    = last;
		r.recovered_kind = kind;
		r.new_source     = nsrc;
		r.gap_recorded   = rec;
		r.gap_ignored    = ign;
		r.exhausted_now  = ex;
		r.pending_count  = pc;
		return r;
	endfunction

endpackage

/* rtl/core/rtpn_entry_eval.sv */
module rtpn_entry_eval (
	input  rtpn_pkg::entry_t ent,
	input  logic [15:0]      seq_ref,
	input  logic [15:0]      base,
	input  logic [31:0]      now,
	input  logic [7:0]       max_att,
	input  logic [63:0]      best_order,
	output rtpn_pkg::eval_t  ev
);

	// Compare one table entry against the current command
	always_comb begin
		ev.seq_eq     = (ent.seq == seq_ref);
		ev.diff       = ent.seq - base;
		ev.due_ok     = (now >= ent.due);
		ev.att_ok     = (ent.attempts < max_att);
		ev.order_lt   = (ent.order < best_order);
		ev.never_sent = (ent.attempts == 8'd0);
	end

endmodule

/* rtl/core/rtpn_table.sv */
module rtpn_table (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [rtpn_pkg::IDX_W-1:0]    wr_addr,
	input  rtpn_pkg::entry_t              wr_data,
	input  logic                          rd_en,
	input  logic [rtpn_pkg::IDX_W-1:0]    rd_addr,
	output rtpn_pkg::entry_t              rd_data
);

	rtpn_pkg::entry_t mem [rtpn_pkg::TABLE_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/rtp_missing_packet_nack_tracker_top.sv */
// RTP missing-packet tracker with NACK scheduling.
// Input channel: in_valid / in_stall with command, source_id, seq_num, time_ms and
// range_count; a word is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with one result word per beat; the last
// word of a command has last_result set. A poll gives one word per due entry, or one word when none is due.
// Config: cfg_wr_en / cfg_index / cfg_data, to be written only while the block is
// idle; the block itself does not enforce this. One word at a time: in_stall stays
// high until the last result of the current word is in the output register. Every
// table pass walks all 64 entries through the single read port of the entry
// memory, through one shared compare unit.
//   observe: one pass, then, when a forward gap is seen, the missing numbers
//   are entered one by one, passing over numbers already pending and occupied
//   slots; poll: one pass to mark the due entries, then a selection pass and an
//   emit step per NACK; abandon: one pass; clear and new source: no pass.
// Reset empties the table, forgets the source and time, and loads the register
// defaults (delay 0, retry 20, attempts 3, capacity 64). No clearing pass is
// needed. When out_stall holds, the sequencer waits with the next result.
module rtp_missing_packet_nack_tracker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] source_id,
	input  logic [15:0] seq_num,
	input  logic [31:0] time_ms,
	input  logic [15:0] range_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        nack_valid,
	output logic [15:0] nack_seq,
	output logic        last_result,
	output logic [1:0]  recovered_kind,
	output logic        new_source,
	output logic [6:0]  gap_recorded,
	output logic [14:0] gap_ignored,
	output logic        exhausted_now,
	output logic [6:0]  pending_count,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int DEPTH = rtpn_pkg::TABLE_DEPTH;

	rtpn_pkg::state_t state_q, state_d;

	logic [15:0] init_delay_q, retry_q;
	logic [7:0]  max_att_q;
	logic [6:0]  max_pend_q;

	logic        src_valid_q, time_valid_q;
	logic [31:0] cur_src_q, latest_q, now_q;
	logic [15:0] highest_q, seq_q, rcount_q;
	logic [63:0] order_q;
	logic [DEPTH-1:0] valid_q, picked_q, present_q;
	logic [6:0]  pend_cnt_q;
	rtpn_pkg::cmd_t cmd_q;

	logic [6:0]  idx_q;
	logic        rd_pend_s1;
	logic [5:0]  rd_idx_s1;

	logic [1:0]  hit_kind_q;
	logic [14:0] gap_q;
	logic        fwd_ok_q;
	logic [6:0]  tracked_q, off_q, slot_q, rec_q, n_q;
	logic [31:0] due_q;
	rtpn_pkg::entry_t best_q;
	logic [5:0]  best_idx_q;
	logic        best_found_q;

	rtpn_pkg::result_t res_q, out_q;
	logic        out_valid_q;

	// Control
	logic        in_acc, out_free, scan_done, ins_done, ins_write;
	logic        is_scan_q, is_scan_d, scan_start, scan_run, ev_act, ev_v;
	logic        rd_en, wr_en, load_out;
	logic [5:0]  wr_addr, off_idx;
	rtpn_pkg::entry_t wr_data, rd_data;
	rtpn_pkg::eval_t  ev;
	logic [15:0] base, fwd_c, d_m1;
	logic [31:0] now_c;
	logic        new_src_c;
	logic [6:0]  cap_c, avail_c, tracked_c;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_done = idx_q[6] && !rd_pend_s1;
	assign ins_done  = (off_q > tracked_q) || slot_q[6];
	assign off_idx   = 6'(off_q - 7'd1);
	assign ins_write = !ins_done && !present_q[off_idx] && !valid_q[slot_q[5:0]];
	assign ev_act    = scan_run && rd_pend_s1;
	assign ev_v      = valid_q[rd_idx_s1];

	assign now_c     = (!time_valid_q || time_ms > latest_q) ? time_ms : latest_q;
	assign new_src_c = !src_valid_q || (cur_src_q != source_id);
	assign fwd_c     = seq_num - highest_q;
	assign base      = (state_q == rtpn_pkg::S_ABN_SCAN) ? seq_q : highest_q;
	assign d_m1      = ev.diff - 16'd1;

	// Capacity left for new missing numbers
	assign cap_c     = (max_pend_q < 7'(DEPTH)) ? max_pend_q : 7'(DEPTH);
	assign avail_c   = (pend_cnt_q < cap_c) ? (cap_c - pend_cnt_q) : 7'd0;
	assign tracked_c = (gap_q < {8'd0, avail_c}) ? gap_q[6:0] : avail_c;

	rtpn_entry_eval u_eval (
		.ent        (rd_data),
		.seq_ref    (seq_q),
		.base       (base),
		.now        (now_q),
		.max_att    (max_att_q),
		.best_order (best_q.order),
		.ev         (ev)
	);

	rtpn_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[5:0]),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rtpn_pkg::S_IDLE: begin
				if (in_valid) begin
					case (rtpn_pkg::cmd_t'(command))
						rtpn_pkg::CMD_OBSERVE:
							state_d = new_src_c ? rtpn_pkg::S_OUT : rtpn_pkg::S_OBS_SCAN;
						rtpn_pkg::CMD_TICK:    state_d = rtpn_pkg::S_TICK_SCAN;
						rtpn_pkg::CMD_ABANDON: state_d = rtpn_pkg::S_ABN_SCAN;
						default:               state_d = rtpn_pkg::S_OUT;
					endcase
				end
			end
			rtpn_pkg::S_OBS_SCAN: begin
				if (scan_done) state_d = fwd_ok_q ? rtpn_pkg::S_OBS_INS : rtpn_pkg::S_OUT;
			end
			rtpn_pkg::S_OBS_INS: begin
				if (ins_done) state_d = rtpn_pkg::S_OUT;
			end
			rtpn_pkg::S_TICK_SCAN: begin
				if (scan_done) state_d = (n_q == 7'd0) ? rtpn_pkg::S_OUT : rtpn_pkg::S_TICK_SEL;
			end
			rtpn_pkg::S_TICK_SEL: begin
				if (scan_done) state_d = rtpn_pkg::S_TICK_EMIT;
			end
			rtpn_pkg::S_TICK_EMIT: state_d = rtpn_pkg::S_OUT;
			rtpn_pkg::S_ABN_SCAN: begin
				if (scan_done) state_d = rtpn_pkg::S_OUT;
			end
			rtpn_pkg::S_OUT: begin
				if (out_free) begin
					state_d = (cmd_q == rtpn_pkg::CMD_TICK && n_q != 7'd0) ?
						rtpn_pkg::S_TICK_SEL : rtpn_pkg::S_IDLE;
				end
			end
			default: state_d = rtpn_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != rtpn_pkg::S_IDLE);
		is_scan_q = (state_q == rtpn_pkg::S_OBS_SCAN) || (state_q == rtpn_pkg::S_TICK_SCAN) ||
			(state_q == rtpn_pkg::S_TICK_SEL) || (state_q == rtpn_pkg::S_ABN_SCAN);
		is_scan_d = (state_d == rtpn_pkg::S_OBS_SCAN) || (state_d == rtpn_pkg::S_TICK_SCAN) ||
			(state_d == rtpn_pkg::S_TICK_SEL) || (state_d == rtpn_pkg::S_ABN_SCAN);
		scan_start = is_scan_d && (state_d != state_q);
		scan_run   = is_scan_q && !scan_start;
		rd_en      = scan_run && !idx_q[6];
		load_out   = (state_q == rtpn_pkg::S_OUT) && out_free;
		wr_en      = 1'b0;
		wr_addr    = slot_q[5:0];
		wr_data.seq      = highest_q + {9'd0, off_q};
		wr_data.due      = due_q;
		wr_data.attempts = 8'd0;
		wr_data.order    = order_q;
		if (state_q == rtpn_pkg::S_OBS_INS) begin
			wr_en = ins_write;
		end else if (state_q == rtpn_pkg::S_TICK_EMIT) begin
			wr_en            = 1'b1;
			wr_addr          = best_idx_q;
			wr_data.seq      = best_q.seq;
			wr_data.due      = rtpn_pkg::sat_add(now_q, retry_q);
			wr_data.attempts = best_q.attempts + 8'd1;
			wr_data.order    = best_q.order;
		end
	end

	// Registers, state and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rtpn_pkg::S_IDLE;
			init_delay_q <= rtpn_pkg::INIT_DELAY_RST;
			retry_q      <= rtpn_pkg::RETRY_RST;
			max_att_q    <= rtpn_pkg::MAX_ATT_RST;
			max_pend_q   <= rtpn_pkg::MAX_PEND_RST;
			src_valid_q  <= 1'b0;
			cur_src_q    <= '0;
			highest_q    <= '0;
			time_valid_q <= 1'b0;
			latest_q     <= '0;
			order_q      <= '0;
			valid_q      <= '0;
			pend_cnt_q   <= '0;
			idx_q        <= '0;
			rd_pend_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			best_found_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Configuration writes
			if (cfg_wr_en) begin
				case (rtpn_pkg::reg_idx_t'(cfg_index))
					rtpn_pkg::REG_INIT_DELAY: init_delay_q <= cfg_data;
					rtpn_pkg::REG_RETRY:      retry_q      <= cfg_data;
					rtpn_pkg::REG_MAX_ATT:    max_att_q    <= cfg_data[7:0];
					rtpn_pkg::REG_MAX_PEND:   max_pend_q   <= cfg_data[6:0];
					default: ;
				endcase
			end

			// Advance the scan pointer and read pipeline
			if (scan_start) begin
				idx_q        <= '0;
				rd_pend_s1   <= 1'b0;
				best_found_q <= 1'b0;
			end else if (scan_run) begin
				rd_pend_s1 <= !idx_q[6];
				rd_idx_s1  <= idx_q[5:0];
				if (!idx_q[6]) idx_q <= idx_q + 7'd1;
			end

			// Take a new word
			if (in_acc) begin
				cmd_q    <= rtpn_pkg::cmd_t'(command);
				seq_q    <= seq_num;
				rcount_q <= range_count;
				now_q    <= now_c;
				case (rtpn_pkg::cmd_t'(command))
					rtpn_pkg::CMD_OBSERVE: begin
						latest_q     <= now_c;
						time_valid_q <= 1'b1;
						if (new_src_c) begin
							valid_q     <= '0;
							pend_cnt_q  <= '0;
							order_q     <= '0;
							src_valid_q <= 1'b1;
							cur_src_q   <= source_id;
							highest_q   <= seq_num;
							res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1,
								rtpn_pkg::KIND_NONE, 1'b1, 7'd0, 15'd0, 1'b0, 7'd0);
						end else begin
							hit_kind_q <= rtpn_pkg::KIND_NONE;
							present_q  <= '0;
							fwd_ok_q   <= (fwd_c != 16'd0) && (fwd_c < rtpn_pkg::HALF_SPACE);
							gap_q      <= 15'(fwd_c - 16'd1);
						end
					end
					rtpn_pkg::CMD_TICK: begin
						latest_q     <= now_c;
						time_valid_q <= 1'b1;
						n_q          <= '0;
						picked_q     <= '0;
					end
					rtpn_pkg::CMD_ABANDON: ;
					default: begin
						valid_q      <= '0;
						pend_cnt_q   <= '0;
						src_valid_q  <= 1'b0;
						cur_src_q    <= '0;
						highest_q    <= '0;
						time_valid_q <= 1'b0;
						latest_q     <= '0;
						order_q      <= '0;
						res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1,
							rtpn_pkg::KIND_NONE, 1'b0, 7'd0, 15'd0, 1'b0, 7'd0);
					end
				endcase
			end

			case (state_q)
				// Drop an arrival that was pending and mark numbers already in the table
				rtpn_pkg::S_OBS_SCAN: begin
					if (ev_act && ev_v) begin
						if (ev.seq_eq) begin
							valid_q[rd_idx_s1] <= 1'b0;
							pend_cnt_q <= pend_cnt_q - 7'd1;
							hit_kind_q <= ev.never_sent ? rtpn_pkg::KIND_BEFORE :
								rtpn_pkg::KIND_AFTER;
						end
						if (ev.diff != 16'd0 && d_m1 < 16'(DEPTH)) begin
							present_q[d_m1[5:0]] <= 1'b1;
						end
					end
					if (scan_done) begin
						tracked_q <= tracked_c;
						due_q     <= rtpn_pkg::sat_add(now_q, init_delay_q);
						off_q     <= 7'd1;
						slot_q    <= '0;
						rec_q     <= '0;
						if (!fwd_ok_q) begin
							res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1, hit_kind_q,
								1'b0, 7'd0, 15'd0, 1'b0, pend_cnt_q);
						end
					end
				end
				// Fill missing numbers into free slots in order
				rtpn_pkg::S_OBS_INS: begin
					if (ins_done) begin
						highest_q <= seq_q;
						res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1, hit_kind_q, 1'b0,
							rec_q, gap_q - {8'd0, rec_q}, 1'b0, pend_cnt_q);
					end else if (present_q[off_idx]) begin
						off_q <= off_q + 7'd1;
					end else if (valid_q[slot_q[5:0]]) begin
						slot_q <= slot_q + 7'd1;
					end else begin
						valid_q[slot_q[5:0]] <= 1'b1;
						pend_cnt_q <= pend_cnt_q + 7'd1;
						order_q    <= order_q + 64'd1;
						rec_q      <= rec_q + 7'd1;
						off_q      <= off_q + 7'd1;
						slot_q     <= slot_q + 7'd1;
					end
				end
				// Mark due entries
				rtpn_pkg::S_TICK_SCAN: begin
					if (ev_act && ev_v && ev.att_ok && ev.due_ok) begin
						picked_q[rd_idx_s1] <= 1'b1;
						n_q <= n_q + 7'd1;
					end
					if (scan_done && n_q == 7'd0) begin
						res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1,
							rtpn_pkg::KIND_NONE, 1'b0, 7'd0, 15'd0, 1'b0, pend_cnt_q);
					end
				end
				// Find the oldest marked entry
				rtpn_pkg::S_TICK_SEL: begin
					if (ev_act && picked_q[rd_idx_s1] && (!best_found_q || ev.order_lt)) begin
						best_q       <= rd_data;
						best_idx_q   <= rd_idx_s1;
						best_found_q <= 1'b1;
					end
				end
				// Count the attempt and report the NACK
				rtpn_pkg::S_TICK_EMIT: begin
					picked_q[best_idx_q] <= 1'b0;
					n_q <= n_q - 7'd1;
					res_q <= rtpn_pkg::make_result(1'b1, best_q.seq, n_q == 7'd1,
						rtpn_pkg::KIND_NONE, 1'b0, 7'd0, 15'd0,
						(best_q.attempts + 8'd1) == max_att_q, pend_cnt_q);
				end
				// Drop entries inside the abandoned range
				rtpn_pkg::S_ABN_SCAN: begin
					if (ev_act && ev_v && ev.diff < rcount_q) begin
						valid_q[rd_idx_s1] <= 1'b0;
						pend_cnt_q <= pend_cnt_q - 7'd1;
					end
					if (scan_done) begin
						res_q <= rtpn_pkg::make_result(1'b0, 16'd0, 1'b1,
							rtpn_pkg::KIND_NONE, 1'b0, 7'd0, 15'd0, 1'b0, pend_cnt_q);
					end
				end
				default: ;
			endcase

			// Output register
			if (load_out) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign nack_valid     = out_q.nack_valid;
	assign nack_seq       = out_q.nack_seq;
	assign last_result    = out_q.last_result;
	assign recovered_kind = out_q.recovered_kind;
	assign new_source     = out_q.new_source;
	assign gap_recorded   = out_q.gap_recorded;
	assign gap_ignored    = out_q.gap_ignored;
	assign exhausted_now  = out_q.exhausted_now;
	assign pending_count  = out_q.pending_count;

	`RTPN_ASSERT(a_pend_cnt, clk, arst_n, pend_cnt_q == 7'($countones(valid_q)))
	`RTPN_ASSERT(a_emit_sel, clk, arst_n, (state_q != rtpn_pkg::S_TICK_EMIT) || (best_found_q && n_q != 7'd0))
	`RTPN_ASSERT(a_fill_cap, clk, arst_n, (state_q != rtpn_pkg::S_OBS_INS) || (rec_q <= tracked_q))
	`RTPN_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, state_q != rtpn_pkg::S_IDLE)

endmodule

/* tb/rtpn_checker.sv */
`timescale 1ns / 1ps

// Watches the input, output and register channels of the NACK tracker,
// predicts every result word and checks what comes out against it.
module rtpn_checker
	import rtpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] source_id,
	input  logic [15:0] seq_num,
	input  logic [31:0] time_ms,
	input  logic [15:0] range_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        nack_valid,
	input  logic [15:0] nack_seq,
	input  logic        last_result,
	input  logic [1:0]  recovered_kind,
	input  logic        new_source,
	input  logic [6:0]  gap_recorded,
	input  logic [14:0] gap_ignored,
	input  logic        exhausted_now,
	input  logic [6:0]  pending_count,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          waiting
);

	localparam int DEPTH = TABLE_DEPTH;

	// register copies
	logic [15:0] delay_ms;
	logic [15:0] retry_ms;
	logic [7:0]  attempt_cap;
	logic [6:0]  pend_cap;

	// tracking state
	bit              src_known;
	logic [31:0]     src_cur;
	logic [15:0]     top_seq;
	bit              clock_known;
	logic [31:0]     clock_ms;
	longint unsigned next_order;
	bit              slot_used [DEPTH];
	logic [15:0]     slot_seq [DEPTH];
	logic [31:0]     slot_due [DEPTH];
	logic [7:0]      slot_tries [DEPTH];
	longint unsigned slot_order [DEPTH];

	result_t expected_words[$];

	function automatic logic [31:0] due_after(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic int slots_in_use();
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i]) n++;
		return n;
	endfunction

	function automatic int slot_of(input logic [15:0] s);
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i] && slot_seq[i] == s) return i;
		return -1;
	endfunction

	task automatic forget_all();
		src_known = 0;
		src_cur = '0;
		top_seq = '0;
		clock_known = 0;
		clock_ms = '0;
		next_order = 0;
		for (int i = 0; i < DEPTH; i++) slot_used[i] = 0;
	endtask

	task automatic add_word(input logic nv, input logic [15:0] ns, input logic last,
			input kind_t kind, input logic nsrc, input int rec, input int ign,
			input logic ex, input int pc);
		result_t w;
		w.nack_valid     = nv;
		w.nack_seq       = ns;
		w.last_result    = last;
		w.recovered_kind = kind;
		w.new_source     = nsrc;
		w.gap_recorded   = rec[6:0];
		w.gap_ignored    = ign[14:0];
		w.exhausted_now  = ex;
		w.pending_count  = pc[6:0];
		expected_words = {expected_words, w};
	endtask

	// Advance the effective time; an older stamp counts as the latest one.
	function automatic logic [31:0] advance_clock(input logic [31:0] t);
		if (!clock_known || t > clock_ms) begin
			clock_ms = t;
			clock_known = 1;
		end
		return clock_ms;
	endfunction

	// Work out the result words of one accepted word.
	task automatic track_word(input cmd_t cmd, input logic [31:0] src, input logic [15:0] seq,
			input logic [31:0] t, input logic [15:0] rc);
		logic [31:0] now;
		logic [31:0] due;
		logic [15:0] fwd;
		logic [15:0] s;
		kind_t kind;
		int hit, gap, cap, pc, avail, tracked, rec, n, best;
		bit picked [DEPTH];
		case (cmd)
			CMD_OBSERVE: begin
				now = advance_clock(t);
				if (!src_known || src_cur != src) begin
					forget_all();
					src_known = 1;
					src_cur = src;
					top_seq = seq;
					clock_known = 1;
					clock_ms = now;
					add_word(0, 0, 1, KIND_NONE, 1, 0, 0, 0, 0);
				end else begin
					kind = KIND_NONE;
					rec = 0;
					gap = 0;
					hit = slot_of(seq);
					if (hit >= 0) begin
						kind = (slot_tries[hit] == 0) ? KIND_BEFORE : KIND_AFTER;
						slot_used[hit] = 0;
					end
					fwd = seq - top_seq;
					if (fwd != 0 && fwd < HALF_SPACE) begin
						gap = int'(fwd) - 1;
						cap = (pend_cap < DEPTH) ? int'(pend_cap) : DEPTH;
						pc = slots_in_use();
						avail = (pc < cap) ? cap - pc : 0;
						tracked = (gap < avail) ? gap : avail;
						due = due_after(now, delay_ms);
						for (int off = 1; off <= tracked; off++) begin
							s = top_seq + 16'(off);
							if (slot_of(s) < 0) begin
								for (int i = 0; i < DEPTH; i++) begin
									if (!slot_used[i]) begin
										slot_used[i] = 1;
										slot_seq[i] = s;
										slot_due[i] = due;
										slot_tries[i] = 0;
										slot_order[i] = next_order;
										next_order++;
										rec++;
										break;
									end
								end
							end
						end
						top_seq = seq;
					end
					add_word(0, 0, 1, kind, 0, rec, gap - rec, 0, slots_in_use());
				end
			end
			CMD_TICK: begin
				now = advance_clock(t);
				pc = slots_in_use();
				n = 0;
				for (int i = 0; i < DEPTH; i++) begin
					picked[i] = slot_used[i] && slot_tries[i] < attempt_cap &&
						now >= slot_due[i];
					if (picked[i]) n++;
				end
				if (n == 0)
					add_word(0, 0, 1, KIND_NONE, 0, 0, 0, 0, pc);
				// emit in detection order
				for (int k = 0; k < n; k++) begin
					best = -1;
					for (int i = 0; i < DEPTH; i++)
						if (picked[i] && (best < 0 || slot_order[i] < slot_order[best]))
							best = i;
					picked[best] = 0;
					slot_tries[best] = slot_tries[best] + 8'd1;
					slot_due[best] = due_after(now, retry_ms);
					add_word(1, slot_seq[best], k == n - 1, KIND_NONE, 0, 0, 0,
						slot_tries[best] == attempt_cap, pc);
				end
			end
			CMD_ABANDON: begin
				for (int i = 0; i < DEPTH; i++)
					if (slot_used[i] && (slot_seq[i] - seq) < rc) slot_used[i] = 0;
				add_word(0, 0, 1, KIND_NONE, 0, 0, 0, 0, slots_in_use());
			end
			default: begin
				forget_all();
				add_word(0, 0, 1, KIND_NONE, 0, 0, 0, 0, 0);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t exp_w;
		if (!arst_n) begin
			delay_ms = INIT_DELAY_RST;
			retry_ms = RETRY_RST;
			attempt_cap = MAX_ATT_RST;
			pend_cap = MAX_PEND_RST;
			forget_all();
			expected_words.delete();
			fails <= 0;
			waiting <= 0;
		end else begin
			// check an output word against the oldest prediction
			if (out_valid && !out_stall) begin
				got = make_result(nack_valid, nack_seq, last_result, recovered_kind,
					new_source, gap_recorded, gap_ignored, exhausted_now, pending_count);
				if (expected_words.size() == 0) begin
					$error("unexpected result word: %p", got);
					fails <= fails + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (got != exp_w) begin
						fails <= fails + 1;
						if (got.nack_valid !== exp_w.nack_valid)
							$error("nack_valid: expected %0d, got %0d",
								exp_w.nack_valid, got.nack_valid);
						if (got.nack_seq !== exp_w.nack_seq)
							$error("nack_seq: expected %0d, got %0d",
								exp_w.nack_seq, got.nack_seq);
						if (got.last_result !== exp_w.last_result)
							$error("last_result: expected %0d, got %0d",
								exp_w.last_result, got.last_result);
						if (got.recovered_kind !== exp_w.recovered_kind)
							$error("recovered_kind: expected %0d, got %0d",
								exp_w.recovered_kind, got.recovered_kind);
						if (got.new_source !== exp_w.new_source)
							$error("new_source: expected %0d, got %0d",
								exp_w.new_source, got.new_source);
						if (got.gap_recorded !== exp_w.gap_recorded)
							$error("gap_recorded: expected %0d, got %0d",
								exp_w.gap_recorded, got.gap_recorded);
						if (got.gap_ignored !== exp_w.gap_ignored)
							$error("gap_ignored: expected %0d, got %0d",
								exp_w.gap_ignored, got.gap_ignored);
						if (got.exhausted_now !== exp_w.exhausted_now)
							$error("exhausted_now: expected %0d, got %0d",
								exp_w.exhausted_now, got.exhausted_now);
						if (got.pending_count !== exp_w.pending_count)
							$error("pending_count: expected %0d, got %0d",
								exp_w.pending_count, got.pending_count);
					end
				end
			end
			// track register writes
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_INIT_DELAY: delay_ms = cfg_data;
					REG_RETRY:      retry_ms = cfg_data;
					REG_MAX_ATT:    attempt_cap = cfg_data[7:0];
					default:        pend_cap = cfg_data[6:0];
				endcase
			end
			// predict an accepted input word
			if (in_valid && !in_stall)
				track_word(cmd_t'(command), source_id, seq_num, time_ms, range_count);
			waiting <= expected_words.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import rtpn_pkg::*;

	localparam int QUIET_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [31:0] source_id;
	logic [15:0] seq_num;
	logic [31:0] time_ms;
	logic [15:0] range_count;
	logic        out_valid;
	logic        out_stall;
	logic        nack_valid;
	logic [15:0] nack_seq;
	logic        last_result;
	logic [1:0]  recovered_kind;
	logic        new_source;
	logic [6:0]  gap_recorded;
	logic [14:0] gap_ignored;
	logic        exhausted_now;
	logic [6:0]  pending_count;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int fails;
	int waiting;
	int idle_pct;
	int stall_pct;
	bit press_go;
	bit press_done;
	int hold_left;
	int quiet;

	// stream state of the generator
	logic [31:0] gen_src;
	logic [15:0] gen_seq;
	logic [31:0] gen_ms;

	rtp_missing_packet_nack_tracker_top uut (.*);

	rtpn_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			hold_left <= 0;
			press_done <= 0;
		end else begin
			if (press_go && !press_done) begin
				hold_left <= 400;
				press_done <= 1;
				out_stall <= 1;
			end else begin
				if (hold_left > 0) hold_left <= hold_left - 1;
				out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one word and hold it until taken.
	task automatic send_word(input cmd_t c, input logic [31:0] s, input logic [15:0] q,
			input logic [31:0] t, input logic [15:0] r);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		command <= c;
		source_id <= s;
		seq_num <= q;
		time_ms <= t;
		range_count <= r;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drain the block, then load all four registers.
	task automatic load_regs(input logic [15:0] dly, input logic [15:0] rty,
			input logic [7:0] att, input logic [6:0] pend);
		in_valid <= 0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_index <= REG_INIT_DELAY;
		cfg_data <= dly;
		@(posedge clk);
		cfg_index <= REG_RETRY;
		cfg_data <= rty;
		@(posedge clk);
		cfg_index <= REG_MAX_ATT;
		cfg_data <= {8'd0, att};
		@(posedge clk);
		cfg_index <= REG_MAX_PEND;
		cfg_data <= {9'd0, pend};
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	// One random word, mostly a well-formed packet stream with polls.
	task automatic random_word();
		int pick;
		logic [15:0] q;
		logic [15:0] rc;
		pick = $urandom_range(99);
		if (pick < 3) begin
			send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		end else if (pick < 7) begin
			// switch source and restart the clock anywhere
			gen_src = $urandom;
			gen_seq = $urandom;
			gen_ms = ($urandom_range(99) < 30) ? $urandom : $urandom_range(0, 1000);
			send_word(CMD_OBSERVE, gen_src, gen_seq, gen_ms, $urandom);
		end else if (pick < 32) begin
			gen_ms = gen_ms + $urandom_range(0, 40);
			send_word(CMD_TICK, $urandom, $urandom, gen_ms, $urandom);
		end else if (pick < 38) begin
			q = gen_seq - 16'($urandom_range(0, 100));
			rc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
			send_word(CMD_ABANDON, $urandom, q, gen_ms, rc);
		end else if (pick < 48) begin
			// late arrival, often of a missing number
			q = gen_seq - 16'($urandom_range(1, 90));
			send_word(CMD_OBSERVE, gen_src, q,
				($urandom_range(4) == 0) ? gen_ms - 10 : gen_ms, $urandom);
		end else if (pick < 51) begin
			q = $urandom;
			if (q - gen_seq < HALF_SPACE) gen_seq = q;
			send_word(CMD_OBSERVE, gen_src, q, gen_ms, $urandom);
		end else begin
			gen_seq = gen_seq + (($urandom_range(99) < 70) ? 16'd1 : 16'($urandom_range(2, 40)));
			gen_ms = gen_ms + $urandom_range(0, 5);
			send_word(CMD_OBSERVE, gen_src, gen_seq, gen_ms, $urandom);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		command = CMD_OBSERVE;
		source_id = 0;
		seq_num = 0;
		time_ms = 0;
		range_count = 0;
		cfg_wr_en = 0;
		cfg_index = REG_INIT_DELAY;
		cfg_data = 0;
		idle_pct = 0;
		stall_pct = 0;
		press_go = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: wrap, recovery before and after NACK, capacity, exhaustion
		send_word(CMD_OBSERVE, 32'h0, 16'hFFFF, 32'd0, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0003, 32'd5, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0001, 32'd6, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd6, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0002, 32'd7, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0003, 32'd7, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0000, 32'd8, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h0050, 32'd9, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd100, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd100, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd121, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd150, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd3, 16'h0);
		send_word(CMD_ABANDON, 32'h0, 16'h0010, 32'd0, 16'h0000);
		send_word(CMD_ABANDON, 32'h0, 16'h0020, 32'd0, 16'h0008);
		send_word(CMD_ABANDON, 32'h0, 16'hFFF0, 32'd0, 16'h0030);
		send_word(CMD_OBSERVE, 32'h0, 16'h8050, 32'd200, 16'h0);
		send_word(CMD_OBSERVE, 32'h0, 16'h804F, 32'd2, 16'hFFFF);
		send_word(CMD_ABANDON, 32'h0, 16'h0000, 32'd0, 16'hFFFF);
		send_word(CMD_CLEAR, 32'h0, 16'h0, 32'd0, 16'h0);

		// directed: saturated due times, single-entry capacity
		load_regs(16'hFFFF, 16'hFFFF, 8'd255, 7'd1);
		send_word(CMD_OBSERVE, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FF00, 16'h0);
		send_word(CMD_OBSERVE, 32'hFFFF_FFFF, 16'h0005, 32'hFFFF_FF00, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'h0);

		// directed: zero attempts and zero capacity
		load_regs(16'd0, 16'd1, 8'd0, 7'd0);
		send_word(CMD_OBSERVE, 32'h1234_5678, 16'h0100, 32'd10, 16'h0);
		send_word(CMD_OBSERVE, 32'h1234_5678, 16'h0108, 32'd10, 16'h0);
		send_word(CMD_TICK, 32'h0, 16'h0, 32'd50, 16'h0);

		// random phases under different registers and handshake pressure
		gen_src = $urandom;
		gen_seq = $urandom;
		gen_ms = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: load_regs(16'd0, 16'd20, 8'd3, 7'd64);
				1: load_regs(16'd15, 16'd1, 8'd1, 7'd127);
				2: load_regs(16'($urandom_range(0, 60)), 16'($urandom_range(1, 60)),
					8'($urandom_range(1, 255)), 7'($urandom_range(1, 64)));
				default: load_regs(16'd65535, 16'd5, 8'd2, 7'd12);
			endcase
			idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 7) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 84 : 7) : 0;
			if (ph == 0) press_go <= 1;
			for (int k = 0; k < 110; k++) random_word();
		end

		// drain and give the verdict
		in_valid <= 0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rtpn_pkg.sv
rtl/core/rtpn_entry_eval.sv
rtl/core/rtpn_table.sv
rtl/core/rtp_missing_packet_nack_tracker_top.sv
tb/rtpn_checker.sv
tb/tb_top.sv
